// File: rtl/triangle_area_3d_assert.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef TRIANGLE_AREA_3D_ASSERT_SVH
`define TRIANGLE_AREA_3D_ASSERT_SVH

// same-cycle implication
`define TRI3D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle_area_3d: same-cycle check failed");

// next-cycle implication
`define TRI3D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle_area_3d: next-cycle check failed");

`endif

// File: rtl/tri3d_pkg.sv
package tri3d_pkg;

  // fixed port widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned AreaW  = 26;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [AreaW-1:0]  area_t;

endpackage

// File: rtl/tri3d_cross.sv
module tri3d_cross #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  tri3d_pkg::coord_t             a_x_i,
  input  tri3d_pkg::coord_t             a_y_i,
  input  tri3d_pkg::coord_t             a_z_i,
  input  tri3d_pkg::coord_t             b_x_i,
  input  tri3d_pkg::coord_t             b_y_i,
  input  tri3d_pkg::coord_t             b_z_i,
  input  tri3d_pkg::coord_t             c_x_i,
  input  tri3d_pkg::coord_t             c_y_i,
  input  tri3d_pkg::coord_t             c_z_i,
  output logic                          valid_o,
  output logic [4*COORD_BITS+3:0]       sum_o
);
  import tri3d_pkg::*;

  localparam int unsigned EW   = COORD_BITS + 1;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned XW   = PW + 1;
  localparam int unsigned SumW = 4 * COORD_BITS + 4;

  // stage valids: edges, products, cross, squares, sum
  logic [4:0] v_q;

  // edge vectors u = b - a, v = c - a
  logic signed [EW-1:0] ux_d, uy_d, uz_d, vx_d, vy_d, vz_d;
  logic signed [EW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;

  // cross product partial products
  logic signed [PW-1:0] p0_d, p1_d, p2_d, p3_d, p4_d, p5_d;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;

  logic signed [XW-1:0] sx_d, sy_d, sz_d;
  logic signed [XW-1:0] sx_q, sy_q, sz_q;

  logic signed [2*XW-1:0] qx_full, qy_full, qz_full;
  logic [SumW-1:0] qx_q, qy_q, qz_q;
  logic [SumW-1:0] sum_d, sum_q;

  function automatic logic signed [EW-1:0] sext(input coord_t c);
    sext = {c[COORD_BITS-1], c[COORD_BITS-1:0]};
  endfunction

  always_comb begin
    ux_d = sext(b_x_i) - sext(a_x_i);
    uy_d = sext(b_y_i) - sext(a_y_i);
    uz_d = sext(b_z_i) - sext(a_z_i);
    vx_d = sext(c_x_i) - sext(a_x_i);
    vy_d = sext(c_y_i) - sext(a_y_i);
    vz_d = sext(c_z_i) - sext(a_z_i);

    p0_d = uy_q * vz_q;
    p1_d = uz_q * vy_q;
    p2_d = uz_q * vx_q;
    p3_d = ux_q * vz_q;
    p4_d = ux_q * vy_q;
    p5_d = uy_q * vx_q;

    sx_d = {p0_q[PW-1], p0_q} - {p1_q[PW-1], p1_q};
    sy_d = {p2_q[PW-1], p2_q} - {p3_q[PW-1], p3_q};
    sz_d = {p4_q[PW-1], p4_q} - {p5_q[PW-1], p5_q};

    // squares are non-negative and below 2^SumW
    qx_full = sx_q * sx_q;
    qy_full = sy_q * sy_q;
    qz_full = sz_q * sz_q;

    sum_d = qx_q + qy_q + qz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= ux_d; uy_q <= uy_d; uz_q <= uz_d;
      vx_q <= vx_d; vy_q <= vy_d; vz_q <= vz_d;
      p0_q <= p0_d; p1_q <= p1_d; p2_q <= p2_d;
      p3_q <= p3_d; p4_q <= p4_d; p5_q <= p5_d;
      sx_q <= sx_d; sy_q <= sy_d; sz_q <= sz_d;
      qx_q <= qx_full[SumW-1:0];
      qy_q <= qy_full[SumW-1:0];
      qz_q <= qz_full[SumW-1:0];
      sum_q <= sum_d;
    end
  end

  assign valid_o = v_q[4];
  assign sum_o   = sum_q;

endmodule

// File: rtl/tri3d_sqrt.sv
module tri3d_sqrt #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [4*COORD_BITS+3:0]   sum_i,
  output logic                      valid_o,
  output tri3d_pkg::area_t          root_o
);
  import tri3d_pkg::*;

  localparam int unsigned SumW  = 4 * COORD_BITS + 4;
  localparam int unsigned RootW = 2 * COORD_BITS + 2;

  // one result bit per stage, most significant first
  logic [RootW-1:0] v_q;
  logic [SumW-1:0]  n_in  [RootW];
  logic [SumW-1:0]  r_in  [RootW];
  logic [SumW-1:0]  n_d   [RootW];
  logic [SumW-1:0]  r_d   [RootW];
  logic [SumW-1:0]  n_q   [RootW];
  logic [SumW-1:0]  r_q   [RootW];
  logic [SumW:0]    trial [RootW];
  logic [SumW+1:0]  diff  [RootW];
  logic [SumW-1:0]  bit_w [RootW];

  always_comb begin
    n_in[0] = sum_i;
    r_in[0] = '0;
    for (int k = 1; k < RootW; k++) begin
      n_in[k] = n_q[k-1];
      r_in[k] = r_q[k-1];
    end
    for (int k = 0; k < RootW; k++) begin
      bit_w[k] = SumW'(1) << (2 * (RootW - 1 - k));
      trial[k] = {1'b0, r_in[k]} + {1'b0, bit_w[k]};
      diff[k]  = {2'b00, n_in[k]} - {1'b0, trial[k]};
      if (!diff[k][SumW+1]) begin
        // remainder covers the trial value: take the bit
        n_d[k] = diff[k][SumW-1:0];
        r_d[k] = (r_in[k] >> 1) | bit_w[k];
      end else begin
        n_d[k] = n_in[k];
        r_d[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RootW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = area_t'(r_q[RootW-1][RootW-1:0]);

endmodule

// File: rtl/tri3d_skid.sv
module tri3d_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tri3d_pkg::area_t  data_i,
  output logic              en_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tri3d_pkg::area_t  out_data_o
);
  import tri3d_pkg::*;

  logic  full_d, full_q;
  area_t hold_q;

  always_comb begin
    if (full_q) begin
      full_d = !out_ready_i;
    end else begin
      full_d = valid_i && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // catch the pipeline head while the pipeline moves on
  always_ff @(posedge clk_i) begin
    if (!full_q) begin
      hold_q <= data_i;
    end
  end

  assign en_o        = !full_q;
  assign out_valid_o = full_q || valid_i;
  assign out_data_o  = full_q ? hold_q : data_i;

endmodule

// File: rtl/triangle_area_3d.sv
// triangle_area_3d: twice the area of a 3D triangle, exact integer arithmetic.
// each request carries vertices a, b, c as signed coordinates; the block forms
// u = b - a and v = c - a, their cross product s, and returns
// double_area_o = floor(sqrt(sx^2 + sy^2 + sz^2)), i.e. twice the area rounded
// down (degenerate triangles give zero). only the low COORD_BITS bits of each
// coordinate port are used, sign-extended. nothing overflows or saturates.
// throughput is one request per cycle while in_ready_o is high. a request
// passes five arithmetic stages (edges, products, cross, squares, sum)
// followed by the square root, which resolves one result bit per pipeline
// stage. a result held back by out_ready_i parks in an output skid register;
// in_ready_o drops only while that register is full.
module triangle_area_3d #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tri3d_pkg::coord_t a_x_i,
  input  tri3d_pkg::coord_t a_y_i,
  input  tri3d_pkg::coord_t a_z_i,
  input  tri3d_pkg::coord_t b_x_i,
  input  tri3d_pkg::coord_t b_y_i,
  input  tri3d_pkg::coord_t b_z_i,
  input  tri3d_pkg::coord_t c_x_i,
  input  tri3d_pkg::coord_t c_y_i,
  input  tri3d_pkg::coord_t c_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tri3d_pkg::area_t  double_area_o
);
  import tri3d_pkg::*;

  localparam int unsigned SumW = 4 * COORD_BITS + 4;

  // global pipeline advance, low only while the skid register is full
  logic            pipe_en;
  logic            acc_valid;
  logic            sum_valid;
  logic [SumW-1:0] sum;
  logic            root_valid;
  area_t           root;

  // a bubble enters when no request is taken
  assign acc_valid  = in_valid_i && pipe_en;
  assign in_ready_o = pipe_en;

  // edges, cross product and sum of squares
  tri3d_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (acc_valid),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .c_z_i   (c_z_i),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  // pipelined integer square root, floor
  tri3d_sqrt #(
    .COORD_BITS(COORD_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .valid_o (root_valid),
    .root_o  (root)
  );

  // output skid register parts the result side from the pipeline
  tri3d_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (root_valid),
    .data_i      (root),
    .en_o        (pipe_en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (double_area_o)
  );

`include "triangle_area_3d_assert.svh"

  // a stalled input always means a result is being offered
  `TRI3D_ASSERT_NOW(a_stall_has_result, !in_ready_o, out_valid_o)
  // an unaccepted result while running parks in the skid register
  `TRI3D_ASSERT_NEXT(a_park_stalls, out_valid_o && !out_ready_i && in_ready_o, !in_ready_o)
  // draining the skid register reopens the input
  `TRI3D_ASSERT_NEXT(a_drain_resumes, !in_ready_o && out_ready_i, in_ready_o)

endmodule

// File: verif/tb_triangle_area_3d.sv
`timescale 1ns / 100ps

module tb_triangle_area_3d;
  import tri3d_pkg::*;

  // one request: the three vertices, a first
  typedef struct packed {
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } tri_t;

  localparam int HoldCycles = 250;   // long receiver hold-off
  localparam int HoldAfter  = 300;   // start it once this many requests went in
  localparam int DrainLimit = 2000;  // cycles allowed for the results to drain
  localparam int Settle     = 40;    // pipeline is 31 deep at the default size
  localparam int MaxPrints  = 100;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  tri_t   req_tri   = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  area_t  double_area;

  tri_t   pending_tris[$];    // requests not yet offered
  area_t  expected_areas[$];  // predicted results, oldest first

  int in_issued     = 0;  // requests raised by the driver
  int in_accepts    = 0;  // requests taken by the block
  int results_seen  = 0;
  int err_count     = 0;
  int cyc           = 0;
  int input_stalls  = 0;
  int flat_count    = 0;  // requests predicted as degenerate
  area_t max_area   = '0;

  int hold_left     = 0;
  bit hold_done     = 1'b0;

  int corner_vals[7] = '{-2048, -2047, -1, 0, 1, 2046, 2047};

  triangle_area_3d dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .a_x_i         (req_tri.ax),
    .a_y_i         (req_tri.ay),
    .a_z_i         (req_tri.az),
    .b_x_i         (req_tri.bx),
    .b_y_i         (req_tri.by),
    .b_z_i         (req_tri.bz),
    .c_x_i         (req_tri.cx),
    .c_y_i         (req_tri.cy),
    .c_z_i         (req_tri.cz),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .double_area_o (double_area)
  );

  always #5 clk = ~clk;

  // floor of the square root, one result bit at a time from the top
  function automatic area_t floor_root(logic [4*CoordW+3:0] n);
    area_t root;
    area_t trial;
    root = '0;
    for (int i = AreaW - 1; i >= 0; i--) begin
      trial = root | (area_t'(1) << i);
      if ((52'(trial) * 52'(trial)) <= n) root = trial;
    end
    return root;
  endfunction

  // length of (b - a) x (c - a), rounded down
  function automatic area_t twice_area(tri_t t);
    logic signed [CoordW:0]     ux, uy, uz, vx, vy, vz;
    logic signed [2*CoordW+1:0] nx, ny, nz;
    logic [2*CoordW+1:0]        mx, my, mz;
    logic [4*CoordW+3:0]        sum;
    // edges need one extra bit
    ux = $signed(t.bx) - $signed(t.ax);
    uy = $signed(t.by) - $signed(t.ay);
    uz = $signed(t.bz) - $signed(t.az);
    vx = $signed(t.cx) - $signed(t.ax);
    vy = $signed(t.cy) - $signed(t.ay);
    vz = $signed(t.cz) - $signed(t.az);
    // normal vector, each component fits in 2*CoordW+2 signed bits
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    mx = nx[2*CoordW+1] ? -nx : nx;
    my = ny[2*CoordW+1] ? -ny : ny;
    mz = nz[2*CoordW+1] ? -nz : nz;
    sum = 52'(mx) * 52'(mx) + 52'(my) * 52'(my) + 52'(mz) * 52'(mz);
    return floor_root(sum);
  endfunction

  function automatic tri_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz);
    tri_t t;
    t.ax = coord_t'(ax); t.ay = coord_t'(ay); t.az = coord_t'(az);
    t.bx = coord_t'(bx); t.by = coord_t'(by); t.bz = coord_t'(bz);
    t.cx = coord_t'(cx); t.cy = coord_t'(cy); t.cz = coord_t'(cz);
    return t;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(15)) - 8;
  endfunction

  function automatic int corner_coord();
    return corner_vals[$urandom_range(6)];
  endfunction

  // a window of the run where neither side idles
  function automatic bit quiet_window();
    return cyc >= 1100 && cyc < 1600;
  endfunction

  function automatic bit take_break();
    return !quiet_window() && $urandom_range(99) < 10;
  endfunction

  task automatic flag_mismatch(string msg);
    err_count++;
    if (err_count <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // driver: offers one request at a time, holds it until taken
  always @(negedge clk) begin
    if (rst_n && in_accepts == in_issued) begin
      if (pending_tris.size() > 0 && !take_break()) begin
        req_tri   <= pending_tris.pop_front();
        in_valid  <= 1'b1;
        in_issued <= in_issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && in_accepts >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  // monitor: predict on request accept, check on result accept
  always @(posedge clk) begin : watch_ports
    area_t want;
    area_t got;
    if (rst_n) begin
      cyc++;
      if (in_valid && in_ready) begin
        want = twice_area(req_tri);
        expected_areas.push_back(want);
        in_accepts++;
        if (want == '0) flat_count++;
        if (want > max_area) max_area = want;
      end
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) begin
        got = double_area;
        results_seen++;
        if (expected_areas.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing outstanding", got));
        end else begin
          want = expected_areas.pop_front();
          if (got !== want)
            flag_mismatch($sformatf("result %0d: double_area %0d, want %0d",
                                    results_seen, got, want));
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : run_main
    tri_t        t;
    logic [127:0] raw;
    int          sel, ax, ay, az, dx, dy, dz, k1, k2;

    // directed: zero, extremes, degenerate cases, small known areas
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(mk_tri(-2048, -2048, -2048, 2047, -2048, -2048,
                                  -2048, 2047, -2048));
    pending_tris.push_back(mk_tri(2047, 2047, 2047, -2048, -2048, -2048, 0, 0, 0));
    pending_tris.push_back(mk_tri(-2048, -2048, -2048, 2047, 2047, 2047, 0, 0, 0));
    pending_tris.push_back(mk_tri(1, 2, 3, 4, 5, 6, 7, 8, 9));
    pending_tris.push_back(mk_tri(100, -200, 300, 55, 66, -77, 55, 66, -77));
    pending_tris.push_back(mk_tri(-5, 7, 9, -5, 7, 9, 1000, -1000, 3));
    pending_tris.push_back(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    pending_tris.push_back(mk_tri(-1, -1, -1, 2047, -1, -1, -1, -1, 2047));
    pending_tris.push_back(mk_tri(2047, -2048, 2047, -2048, 2047, -2048,
                                  2047, 2047, -2048));
    pending_tris.push_back(mk_tri(-2048, 2047, 0, 2047, -2048, 0, 0, 0, 2047));
    repeat (8)
      pending_tris.push_back(mk_tri(corner_coord(), corner_coord(), corner_coord(),
                                    corner_coord(), corner_coord(), corner_coord(),
                                    corner_coord(), corner_coord(), corner_coord()));

    // random mix: full range, tiny triangles, corners, lines, repeated vertices
    repeat (1530) begin
      sel = $urandom_range(99);
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      t   = raw[$bits(tri_t)-1:0];
      if (sel < 55) begin
        // full random as drawn
      end else if (sel < 70) begin
        t = mk_tri(small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord());
      end else if (sel < 82) begin
        t = mk_tri(corner_coord(), corner_coord(), corner_coord(),
                   corner_coord(), corner_coord(), corner_coord(),
                   corner_coord(), corner_coord(), corner_coord());
      end else if (sel < 92) begin
        // all three vertices on one line
        ax = int'($urandom_range(2000)) - 1000;
        ay = int'($urandom_range(2000)) - 1000;
        az = int'($urandom_range(2000)) - 1000;
        dx = int'($urandom_range(20)) - 10;
        dy = int'($urandom_range(20)) - 10;
        dz = int'($urandom_range(20)) - 10;
        k1 = int'($urandom_range(180)) - 90;
        k2 = int'($urandom_range(180)) - 90;
        t = mk_tri(ax, ay, az, ax + k1 * dx, ay + k1 * dy, az + k1 * dz,
                   ax + k2 * dx, ay + k2 * dy, az + k2 * dz);
      end else if (sel < 96) begin
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end else begin
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end
      pending_tris.push_back(t);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every request taken
    while (pending_tris.size() > 0 || in_accepts != in_issued) @(posedge clk);
    // then every result back, bounded
    for (int n = 0; n < DrainLimit && expected_areas.size() > 0; n++) @(posedge clk);
    repeat (Settle) @(posedge clk);
    if (expected_areas.size() > 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_areas.size()));

    $display("covered %0d triangles, %0d degenerate, largest double area %0d",
             in_accepts, flat_count, max_area);
    $display("%0d results checked, %0d input stall cycles, %0d mismatches",
             results_seen, input_stalls, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
